FILE: sv/utcl_pkg.sv
// ----------------------------------------------------------------------------
// utcl_pkg: shared types and constants of the local time converter
// Calendar record, configuration register indexes, the constants of the
// date split and the small month and weekday tables.
// ----------------------------------------------------------------------------
package utcl_pkg;

  // Broken-down calendar date and time of one timestamp.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ZONE_OFFSET     = 3'd0,
    CFG_DST_ENABLE      = 3'd1,
    CFG_DST_START_MONTH = 3'd2,
    CFG_DST_STOP_MONTH  = 3'd3,
    CFG_DST_SHIFT       = 3'd4
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Register reset values.
  localparam logic [16:0] ZONE_OFFSET_RST = 17'd0;
  localparam logic [3:0]  START_MONTH_RST = 4'd3;
  localparam logic [3:0]  STOP_MONTH_RST  = 4'd10;
  localparam logic [12:0] DST_SHIFT_RST   = 13'd3600;

  // Pipeline depths of the date split and the boundary lanes.
  localparam int unsigned SPLIT_LAT = 10;
  localparam int unsigned BND_LAT   = 4;

  // Time constants.
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

  // Reciprocals scaled so that the estimate is exact or one too low.
  localparam logic [15:0] DAY_RECIP  = 16'd49710; // 2^32 / 86400
  localparam logic [10:0] HOUR_RECIP = 11'd1165;  // 2^22 / 3600
  localparam logic [6:0]  MIN_RECIP  = 7'd68;     // 2^12 / 60
  localparam logic [5:0]  QUAD_RECIP = 6'd44;     // 2^16 / 1461
  localparam logic [5:0]  WEEK_RECIP = 6'd36;     // 2^8 / 7

  // Four-year cycles counted from 1968-03-01, with one day added from
  // 2100-03-01 onwards so that the skipped leap day of 2100 is honoured.
  localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
  localparam logic [15:0] EPOCH_SHIFT   = 16'd671;
  localparam logic [15:0] DAY_2100_MAR1 = 16'd47541;
  localparam logic [11:0] BASE_YEAR     = 12'd1968;
  localparam logic [11:0] YEAR_2100     = 12'd2100;
  localparam logic [11:0] YEAR_LOW      = 12'd2000;
  localparam logic [11:0] YEAR_HIGH     = 12'd2099;

  // Day within a March-based year on which each month begins.
  function automatic logic [8:0] mon_start(input logic [3:0] mp);
    logic [8:0] res;
    unique case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Month term of the weekday formula, month given as 1 to 12.
  function automatic logic [2:0] sak_tab(input logic [3:0] m);
    logic [2:0] res;
    unique case (m)
      4'd1:    res = 3'd0;
      4'd2:    res = 3'd3;
      4'd3:    res = 3'd2;
      4'd4:    res = 3'd5;
      4'd5:    res = 3'd0;
      4'd6:    res = 3'd3;
      4'd7:    res = 3'd5;
      4'd8:    res = 3'd1;
      4'd9:    res = 3'd4;
      4'd10:   res = 3'd6;
      4'd11:   res = 3'd2;
      4'd12:   res = 3'd4;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

FILE: sv/utc_to_local_time_with_dst_top.sv
// ----------------------------------------------------------------------------
// utc_to_local_time_with_dst_top: UTC seconds to local calendar time
// Throughput: one conversion per cycle; busy never rises.
// The path runs through the input register, the ten-stage date split, the four
// stages that build the last-Sunday boundaries and one result stage.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module utc_to_local_time_with_dst_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command channel.
  input  logic                            start,
  output logic                            busy,
  input  logic [31:0]                     utc_seconds_i,
  // Result channel.
  output logic                            done_o,
  output logic [31:0]                     local_seconds_o,
  output logic [11:0]                     year_out_o,
  output logic [3:0]                      month_out_o,
  output logic [4:0]                      day_out_o,
  output logic [4:0]                      hour_out_o,
  output logic [5:0]                      minute_out_o,
  output logic [5:0]                      second_out_o,
  output logic                            dst_applied_o,
  output logic                            out_of_range_o,
  // Configuration write port.
  input  logic                            wr_en_i,
  input  logic [utcl_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [utcl_pkg::CFG_DATA_W-1:0] wr_data_i
);
  import utcl_pkg::*;

  localparam int unsigned SIDE_LEN = SPLIT_LAT + BND_LAT;

  // Timestamps carried alongside the date split and boundary stages.
  typedef struct packed {
    logic [31:0] utc;
    logic [31:0] loc;
    logic [31:0] loc2;
  } side_t;

  // Configuration registers.
  logic [16:0] zone_offset_q;
  logic        dst_enable_q;
  logic [3:0]  dst_start_month_q;
  logic [3:0]  dst_stop_month_q;
  logic [12:0] dst_shift_q;

  // Input stage.
  logic        in_vld_q;
  logic [31:0] in_utc_q, in_loc_q, in_loc2_q;
  logic [31:0] loc_d, loc2_d;
  logic        accept;

  // Split outputs.
  logic  base_vld, dst_vld;
  date_t base_date, dst_date;

  // Side line and date delay line.
  logic [SIDE_LEN-1:0] side_vld_q;
  side_t               side_q [SIDE_LEN];
  date_t               base_dly_q [BND_LAT];
  date_t               dst_dly_q [BND_LAT];

  // Boundary lanes: index 0 is the start month, index 1 the stop month.
  logic [3:0]  lane_mon [2];
  logic [15:0] msd_d [2];
  logic [7:0]  sw_d [2];
  logic [15:0] b1_msd_q [2];
  logic [7:0]  b1_sw_q [2];
  logic [15:0] b2_msd_q [2];
  logic [7:0]  b2_sw_q [2];
  logic [4:0]  b2_q_q [2];
  logic [15:0] b3_dd_q [2];
  logic [32:0] bnd_q [2];
  logic [13:0] wq_prod [2];
  logic [3:0]  w_raw [2];
  logic [2:0]  w_d [2];
  logic [15:0] dd_d [2];
  logic [32:0] bnd_d [2];

  // Result stage.
  logic  months_ok, in_window, applied;
  side_t last_side;
  date_t sel_date;
  logic  done_q;
  logic [31:0] local_q;
  date_t out_date_q;
  logic  applied_q, oor_q;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_offset_q     <= ZONE_OFFSET_RST;
      dst_enable_q      <= 1'b0;
      dst_start_month_q <= START_MONTH_RST;
      dst_stop_month_q  <= STOP_MONTH_RST;
      dst_shift_q       <= DST_SHIFT_RST;
    end else if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_idx_i))
        CFG_ZONE_OFFSET:     zone_offset_q     <= wr_data_i[16:0];
        CFG_DST_ENABLE:      dst_enable_q      <= wr_data_i[0];
        CFG_DST_START_MONTH: dst_start_month_q <= wr_data_i[3:0];
        CFG_DST_STOP_MONTH:  dst_stop_month_q  <= wr_data_i[3:0];
        CFG_DST_SHIFT:       dst_shift_q       <= wr_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Every cycle is free to take a command.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Local time with and without the shift; both wrap modulo 2^32.
  always_comb begin
    loc_d  = utc_seconds_i + {{15{zone_offset_q[16]}}, zone_offset_q};
    loc2_d = loc_d + {19'd0, dst_shift_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_utc_q  <= utc_seconds_i;
      in_loc_q  <= loc_d;
      in_loc2_q <= loc2_d;
    end
  end

  // Both candidate local times are split in parallel.
  utcl_split u_split_base (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .time_i  (in_loc_q),
    .valid_o (base_vld),
    .date_o  (base_date)
  );

  utcl_split u_split_dst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .time_i  (in_loc2_q),
    .valid_o (dst_vld),
    .date_o  (dst_date)
  );

  // Side line valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_vld_q <= '0;
    end else begin
      side_vld_q <= {side_vld_q[SIDE_LEN-2:0], in_vld_q};
    end
  end

  // Side line and date delay payload.
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{utc: in_utc_q, loc: in_loc_q, loc2: in_loc2_q};
    for (int i = 1; i < SIDE_LEN; i++) begin
      side_q[i] <= side_q[i-1];
    end
    base_dly_q[0] <= base_date;
    dst_dly_q[0]  <= dst_date;
    for (int i = 1; i < BND_LAT; i++) begin
      base_dly_q[i] <= base_dly_q[i-1];
      dst_dly_q[i]  <= dst_dly_q[i-1];
    end
  end

  // First boundary stage: days to the first of the month and the weekday sum.
  always_comb begin
    lane_mon[0] = dst_start_month_q;
    lane_mon[1] = dst_stop_month_q;
    for (int k = 0; k < 2; k++) begin
      logic        le2;
      logic [11:0] yy;
      logic [7:0]  n;
      logic        ge;
      logic [3:0]  mp;
      logic [16:0] msd_w;
      le2   = (lane_mon[k] <= 4'd2);
      yy    = base_date.year - 12'(le2);
      n     = 8'(yy - BASE_YEAR);
      ge    = (yy >= YEAR_2100);
      mp    = le2 ? lane_mon[k] + 4'd9 : lane_mon[k] - 4'd3;
      msd_w = 17'(n) * 17'd365 + 17'(n[7:2]) + 17'(mon_start(mp))
            - 17'(EPOCH_SHIFT) - 17'(ge);
      msd_d[k] = msd_w[15:0];
      sw_d[k]  = n + 8'(n[7:2]) + 8'(sak_tab(lane_mon[k])) + 8'd12 - 8'(ge);
    end
  end

  // Remaining boundary stages: weekday modulo seven, last Sunday, 01:00.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      wq_prod[k] = 14'(b1_sw_q[k]) * 14'(WEEK_RECIP);
      w_raw[k]   = 4'(b2_sw_q[k] - 8'(8'd7 * 8'(b2_q_q[k])));
      w_d[k]     = (w_raw[k] >= 4'd7) ? 3'(w_raw[k] - 4'd7) : w_raw[k][2:0];
      dd_d[k]    = b2_msd_q[k] + 16'd30 - 16'(w_d[k]);
      bnd_d[k]   = 33'(b3_dd_q[k]) * 33'(SEC_PER_DAY) + 33'(SEC_PER_HOUR);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      b1_msd_q[k] <= msd_d[k];
      b1_sw_q[k]  <= sw_d[k];
      b2_msd_q[k] <= b1_msd_q[k];
      b2_sw_q[k]  <= b1_sw_q[k];
      b2_q_q[k]   <= wq_prod[k][12:8];
      b3_dd_q[k]  <= dd_d[k];
      bnd_q[k]    <= bnd_d[k];
    end
  end

  // Window test on the UTC input, boundaries included, and result select.
  always_comb begin
    last_side = side_q[SIDE_LEN-1];
    months_ok = dst_start_month_q >= 4'd1 && dst_start_month_q <= 4'd12 &&
                dst_stop_month_q >= 4'd1 && dst_stop_month_q <= 4'd12;
    in_window = ({1'b0, last_side.utc} >= bnd_q[0]) &&
                ({1'b0, last_side.utc} <= bnd_q[1]);
    applied   = dst_enable_q && months_ok && in_window;
    sel_date  = applied ? dst_dly_q[BND_LAT-1] : base_dly_q[BND_LAT-1];
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_vld_q[SIDE_LEN-1];
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    local_q    <= applied ? last_side.loc2 : last_side.loc;
    out_date_q <= sel_date;
    applied_q  <= applied;
    oor_q      <= (sel_date.year < YEAR_LOW) || (sel_date.year > YEAR_HIGH);
  end

  assign done_o          = done_q;
  assign local_seconds_o = local_q;
  assign year_out_o      = out_date_q.year;
  assign month_out_o     = out_date_q.month;
  assign day_out_o       = out_date_q.day;
  assign hour_out_o      = out_date_q.hour;
  assign minute_out_o    = out_date_q.minute;
  assign second_out_o    = out_date_q.second;
  assign dst_applied_o   = applied_q;
  assign out_of_range_o  = oor_q;

  // The split outputs must line up with the side line that carries them.
  a_split_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_vld == side_vld_q[SPLIT_LAT-1])
    else $error("date split out of step with the side line");

  a_split_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_vld == dst_vld)
    else $error("the two date splits are out of step");

  // A shift is only added when the window was not empty.
  a_window_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && dst_applied_o) |-> ($past(bnd_q[0]) <= $past(bnd_q[1])))
    else $error("shift applied with an empty daylight saving window");

endmodule

FILE: sv/utcl_split.sv
// ----------------------------------------------------------------------------
// utcl_split: pipelined split of unix seconds into a calendar date
// Ten register stages: day and second of day, then hour, minute and second
// alongside four-year cycle, year in cycle, month and day of month.
// ----------------------------------------------------------------------------
module utcl_split (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [31:0]       time_i,
  output logic              valid_o,
  output utcl_pkg::date_t   date_o
);
  import utcl_pkg::*;

  // Valid bits travelling with the stages.
  logic [SPLIT_LAT-1:0] vld_q;

  // Stage registers.
  logic [17:0] s1_t_q;
  logic [15:0] s1_dq_q;
  logic [17:0] s2_t_q, s2_p_q;
  logic [15:0] s2_dq_q;
  logic [15:0] s3_days_q;
  logic [16:0] s3_rem_q;
  logic [15:0] s4_e_q;
  logic [16:0] s4_rem_q;
  logic [4:0]  s4_hq_q;
  logic [15:0] s5_e_q;
  logic [5:0]  s5_ce_q;
  logic [16:0] s5_rem_q, s5_hp_q;
  logic [4:0]  s5_hq_q;
  logic [15:0] s6_e_q, s6_cp_q;
  logic [5:0]  s6_ce_q;
  logic [4:0]  s6_hh_q;
  logic [11:0] s6_r2_q;
  logic [5:0]  s7_cyc_q, s7_mq_q;
  logic [10:0] s7_r_q;
  logic [4:0]  s7_hh_q;
  logic [11:0] s7_r2_q;
  logic [5:0]  s8_cyc_q, s8_mq_q;
  logic [1:0]  s8_yoe_q;
  logic [8:0]  s8_doy_q;
  logic [4:0]  s8_hh_q;
  logic [11:0] s8_r2_q, s8_mp60_q;
  logic [5:0]  s9_cyc_q;
  logic [1:0]  s9_yoe_q;
  logic [3:0]  s9_mp_q;
  logic [4:0]  s9_dom_q, s9_hh_q;
  logic [5:0]  s9_mm_q, s9_ss_q;
  date_t       date_q;

  // Combinational values of each stage.
  logic [47:0] dq_prod;
  logic [33:0] p_prod;
  logic [17:0] rr;
  logic [15:0] days_d;
  logic [16:0] rem_d;
  logic [15:0] e_d;
  logic [27:0] hq_prod;
  logic [21:0] ce_prod;
  logic [16:0] hp_d;
  logic [16:0] cp_prod;
  logic [12:0] tr;
  logic [4:0]  hh_d;
  logic [11:0] r2_d;
  logic [11:0] er;
  logic [5:0]  cyc_d;
  logic [10:0] r_d;
  logic [18:0] mq_prod;
  logic [1:0]  yoe_d;
  logic [8:0]  doy_d;
  logic [11:0] mp60_d;
  logic [3:0]  mp_d;
  logic [4:0]  dom_d;
  logic [6:0]  sr;
  logic [5:0]  mm_d, ss_d;
  logic [3:0]  month_d;
  logic [11:0] year_d;

  // Day estimate from the reciprocal, and its product back into seconds.
  always_comb begin
    dq_prod = {16'd0, time_i} * 48'(DAY_RECIP);
    p_prod  = 34'(s1_dq_q) * 34'(SEC_PER_DAY);
  end

  // Correct the day count and find the second of day.
  always_comb begin
    rr = s2_t_q - s2_p_q;
    if (rr >= 18'(SEC_PER_DAY)) begin
      days_d = s2_dq_q + 16'd1;
      rem_d  = 17'(rr - 18'(SEC_PER_DAY));
    end else begin
      days_d = s2_dq_q;
      rem_d  = rr[16:0];
    end
  end

  // Shift to the four-year epoch and estimate the hour.
  always_comb begin
    e_d     = s3_days_q + EPOCH_SHIFT + 16'(s3_days_q >= DAY_2100_MAR1);
    hq_prod = 28'(s3_rem_q) * 28'(HOUR_RECIP);
  end

  // Cycle estimate and the seconds covered by the hour estimate.
  always_comb begin
    ce_prod = 22'(s4_e_q) * 22'(QUAD_RECIP);
    hp_d    = 17'(s4_hq_q) * 17'(SEC_PER_HOUR);
  end

  // Cycle product; correct the hour and keep the second of hour.
  always_comb begin
    cp_prod = 17'(s5_ce_q) * 17'(DAYS_PER_QUAD);
    tr      = 13'(s5_rem_q - s5_hp_q);
    if (tr >= 13'(SEC_PER_HOUR)) begin
      hh_d = s5_hq_q + 5'd1;
      r2_d = 12'(tr - 13'(SEC_PER_HOUR));
    end else begin
      hh_d = s5_hq_q;
      r2_d = tr[11:0];
    end
  end

  // Correct the cycle and estimate the minute.
  always_comb begin
    er      = 12'(s6_e_q - s6_cp_q);
    mq_prod = 19'(s6_r2_q) * 19'(MIN_RECIP);
    if (er >= 12'(DAYS_PER_QUAD)) begin
      cyc_d = s6_ce_q + 6'd1;
      r_d   = 11'(er - 12'(DAYS_PER_QUAD));
    end else begin
      cyc_d = s6_ce_q;
      r_d   = er[10:0];
    end
  end

  // Year within the cycle; the last day of a cycle stays in its fourth year.
  always_comb begin
    if (s7_r_q >= 11'd1095) begin
      yoe_d = 2'd3;
    end else if (s7_r_q >= 11'd730) begin
      yoe_d = 2'd2;
    end else if (s7_r_q >= 11'd365) begin
      yoe_d = 2'd1;
    end else begin
      yoe_d = 2'd0;
    end
    doy_d  = 9'(s7_r_q - 11'(11'd365 * 11'(yoe_d)));
    mp60_d = 12'(s7_mq_q) * 12'(SEC_PER_MIN);
  end

  // Month of the March-based year, day of month, and minute correction.
  always_comb begin
    mp_d = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (s8_doy_q >= mon_start(4'(i))) begin
        mp_d = mp_d + 4'd1;
      end
    end
    dom_d = 5'(s8_doy_q - mon_start(mp_d));
    sr    = 7'(s8_r2_q - s8_mp60_q);
    if (sr >= 7'(SEC_PER_MIN)) begin
      mm_d = s8_mq_q + 6'd1;
      ss_d = 6'(sr - 7'(SEC_PER_MIN));
    end else begin
      mm_d = s8_mq_q;
      ss_d = sr[5:0];
    end
  end

  // Calendar month and year; January and February belong to the next year.
  always_comb begin
    month_d = (s9_mp_q < 4'd10) ? s9_mp_q + 4'd3 : s9_mp_q - 4'd9;
    year_d  = BASE_YEAR + 12'({s9_cyc_q, 2'b00}) + 12'(s9_yoe_q)
            + 12'(month_d <= 4'd2);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SPLIT_LAT-2:0], valid_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    s1_t_q    <= time_i[17:0];
    s1_dq_q   <= dq_prod[47:32];
    s2_t_q    <= s1_t_q;
    s2_dq_q   <= s1_dq_q;
    s2_p_q    <= p_prod[17:0];
    s3_days_q <= days_d;
    s3_rem_q  <= rem_d;
    s4_e_q    <= e_d;
    s4_rem_q  <= s3_rem_q;
    s4_hq_q   <= hq_prod[26:22];
    s5_e_q    <= s4_e_q;
    s5_ce_q   <= ce_prod[21:16];
    s5_rem_q  <= s4_rem_q;
    s5_hq_q   <= s4_hq_q;
    s5_hp_q   <= hp_d;
    s6_e_q    <= s5_e_q;
    s6_ce_q   <= s5_ce_q;
    s6_cp_q   <= cp_prod[15:0];
    s6_hh_q   <= hh_d;
    s6_r2_q   <= r2_d;
    s7_cyc_q  <= cyc_d;
    s7_r_q    <= r_d;
    s7_hh_q   <= s6_hh_q;
    s7_r2_q   <= s6_r2_q;
    s7_mq_q   <= mq_prod[17:12];
    s8_cyc_q  <= s7_cyc_q;
    s8_yoe_q  <= yoe_d;
    s8_doy_q  <= doy_d;
    s8_hh_q   <= s7_hh_q;
    s8_r2_q   <= s7_r2_q;
    s8_mq_q   <= s7_mq_q;
    s8_mp60_q <= mp60_d;
    s9_cyc_q  <= s8_cyc_q;
    s9_yoe_q  <= s8_yoe_q;
    s9_mp_q   <= mp_d;
    s9_dom_q  <= dom_d;
    s9_hh_q   <= s8_hh_q;
    s9_mm_q   <= mm_d;
    s9_ss_q   <= ss_d;
    date_q.year   <= year_d;
    date_q.month  <= month_d;
    date_q.day    <= s9_dom_q + 5'd1;
    date_q.hour   <= s9_hh_q;
    date_q.minute <= s9_mm_q;
    date_q.second <= s9_ss_q;
  end

  assign valid_o = vld_q[SPLIT_LAT-1];
  assign date_o  = date_q;

  // The estimate corrections must leave every time field in range.
  a_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (date_o.hour < 5'd24 && date_o.minute < 6'd60 && date_o.second < 6'd60))
    else $error("split produced a time field out of range");

  a_month_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (date_o.month >= 4'd1 && date_o.month <= 4'd12))
    else $error("split produced a month out of range");

  a_day_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (date_o.day >= 5'd1 && date_o.day <= 5'd31 &&
                 date_o.year >= 12'd1970 && date_o.year <= 12'd2106))
    else $error("split produced a day or year out of range");

endmodule
